FILE: rtl/huffman_total_cost_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Huffman total cost block
// Shared property wrappers clocked on clk_i and gated by rst_ni.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TOTAL_COST_DEFINES_SVH
`define HUFFMAN_TOTAL_COST_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define HTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define HTC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/htc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Huffman total cost package
// Field widths and control bundles shared by the cell row, the cost unit
// and the top level.
// ---------------------------------------------------------------------------
package htc_pkg;

  localparam int unsigned WEIGHT_W = 31;
  localparam int unsigned VAL_W    = 63;
  localparam int unsigned COST_W   = 64;

  // Operation applied to every cell of the row in the same cycle.
  typedef struct packed {
    logic ins;     // insert the broadcast value in sorted order
    logic shift2;  // drop the two smallest values, advance the row by two
  } cell_ctl_t;

  // Operation for the merge sum and cost accumulator.
  typedef struct packed {
    logic load;    // register the sum of the two smallest values
    logic add;     // add the registered sum into the cost, saturating
    logic clear;   // return the cost to zero
  } acc_ctl_t;

endpackage

FILE: rtl/huffman_total_cost.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Huffman total cost
// Weighted path length of a Huffman code built from a set of weights.
// ---------------------------------------------------------------------------
// Usage:
//   Send one symbol weight per request on the slave stream; tlast marks
//   the final weight of a set. Weights are kept sorted in a row of
//   MAX_SYMBOLS cells, smallest in cell 0. Weights are taken only while
//   the block collects a set. After the last weight the block merges: the
//   two smallest values leave the row and their sum is registered, then
//   the sum is inserted back and added to the cost. One result request per
//   set goes out on the master stream with the cost in tdata and the
//   saturation flag in tuser. A weight beyond MAX_SYMBOLS is dropped.
//   The input stays open while a finished result waits in the output
//   register; a stalled receiver only holds the next set at its final
//   step. Reset empties the row and clears the cost and the output valid.
// ---------------------------------------------------------------------------
module huffman_total_cost #(
  parameter int unsigned MAX_SYMBOLS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: weight [30:0], zero pad [31]
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: total_cost [62:0], zero pad [63]
  output logic [63:0] m_axis_tdata,
  // tuser: overflowed [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);
  import htc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);

  localparam logic [1:0] S_IN      = 2'd0;
  localparam logic [1:0] S_MERGE_A = 2'd1;
  localparam logic [1:0] S_MERGE_B = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              s_fire;
  logic              out_free;

  cell_ctl_t         cell_ctl;
  acc_ctl_t          acc_ctl;
  logic [VAL_W-1:0]  ins_val;
  logic [VAL_W-1:0]  sum;
  logic [COST_W-1:0] cost;

  logic [VAL_W-1:0]  cell_val [MAX_SYMBOLS];
  logic              cell_go  [MAX_SYMBOLS];

  logic              m_valid_q;
  logic [VAL_W-1:0]  m_cost_q;
  logic              m_ovf_q;

  assign s_axis_tready = (state_q == S_IN);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Broadcast value: the incoming weight, or the merge sum on re-insert.
  assign ins_val = (state_q == S_MERGE_B) ? sum
                                          : {{(VAL_W - WEIGHT_W){1'b0}},
                                             s_axis_tdata[WEIGHT_W-1:0]};

  // Sequencer: collect weights, then alternate remove-two and insert-sum.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cell_ctl     = '0;
    acc_ctl      = '0;
    case (state_q)
      S_IN: begin
        if (s_fire) begin
          // Drop the weight when the row is full.
          if (count_q < CNT_W'(MAX_SYMBOLS)) begin
            cell_ctl.ins = 1'b1;
            count_d      = count_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            state_d = S_MERGE_A;
          end
        end
      end
      S_MERGE_A: begin
        if (count_q > CNT_W'(1)) begin
          cell_ctl.shift2 = 1'b1;
          acc_ctl.load    = 1'b1;
          count_d         = count_q - CNT_W'(2);
          state_d         = S_MERGE_B;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MERGE_B: begin
        cell_ctl.ins = 1'b1;
        acc_ctl.add  = 1'b1;
        count_d      = count_q + CNT_W'(1);
        state_d      = S_MERGE_A;
      end
      S_DONE: begin
        // Hold until the output register is free, then start afresh.
        if (out_free) begin
          acc_ctl.clear = 1'b1;
          count_d       = '0;
          state_d       = S_IN;
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Sorted cell row; each cell looks at its left neighbour for inserts
  // and two places to the right when the two smallest leave.
  for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
    logic [VAL_W-1:0] prev_val;
    logic             prev_go;
    logic [VAL_W-1:0] next2_val;
    logic             occ;

    assign occ = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_go  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_go  = cell_go[i-1];
    end

    if (i + 2 < MAX_SYMBOLS) begin : g_next
      assign next2_val = cell_val[i+2];
    end else begin : g_tail
      assign next2_val = '0;
    end

    htc_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .ins_val_i   (ins_val),
      .occ_i       (occ),
      .prev_val_i  (prev_val),
      .prev_go_i   (prev_go),
      .next2_val_i (next2_val),
      .val_o       (cell_val[i]),
      .go_o        (cell_go[i])
    );
  end

  htc_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .a_i    (cell_val[0]),
    .b_i    (cell_val[1]),
    .sum_o  (sum),
    .cost_o (cost)
  );

  // Output register: saturate the cost to 63 bits and flag it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      m_cost_q <= cost[COST_W-1] ? {VAL_W{1'b1}} : cost[VAL_W-1:0];
      m_ovf_q  <= cost[COST_W-1];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_cost_q};
  assign m_axis_tuser  = m_ovf_q;

  `include "huffman_total_cost_defines.svh"

  `HTC_ASSERT(a_result_from_done, $rose(m_axis_tvalid) |-> $past(state_q == S_DONE), "result raised outside the done step")
  `HTC_ASSERT(a_merge_takes_two, (state_q == S_MERGE_A && count_q > CNT_W'(1)) |=> (count_q == $past(count_q) - CNT_W'(2)), "merge did not remove two values")
  `HTC_ASSERT(a_row_sorted, (state_q == S_MERGE_A && count_q > CNT_W'(1)) |-> (cell_val[0] <= cell_val[1]), "cell row out of order at merge")

endmodule

FILE: rtl/htc_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Huffman total cost sorted cell
// One place of the sorted value row: compare, take the neighbour's value
// or the broadcast value on insert, take the value two places on when
// the two smallest leave.
// ---------------------------------------------------------------------------
module htc_cell (
  input  logic                           clk_i,
  input  htc_pkg::cell_ctl_t             ctl_i,
  input  logic [htc_pkg::VAL_W-1:0]      ins_val_i,
  input  logic                           occ_i,
  input  logic [htc_pkg::VAL_W-1:0]      prev_val_i,
  input  logic                           prev_go_i,
  input  logic [htc_pkg::VAL_W-1:0]      next2_val_i,
  output logic [htc_pkg::VAL_W-1:0]      val_o,
  output logic                           go_o
);
  import htc_pkg::*;

  logic [VAL_W-1:0] val_q;

  // Insert lands at or before this place: empty, or holds a larger value.
  assign go_o  = !occ_i || (ins_val_i < val_q);
  assign val_o = val_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift2) begin
      val_q <= next2_val_i;
    end else if (ctl_i.ins && go_o) begin
      val_q <= prev_go_i ? prev_val_i : ins_val_i;
    end
  end

endmodule

FILE: rtl/htc_acc.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Huffman total cost accumulator
// Registers the merge sum and adds it into a saturating 64-bit cost.
// ---------------------------------------------------------------------------
module htc_acc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  htc_pkg::acc_ctl_t              ctl_i,
  input  logic [htc_pkg::VAL_W-1:0]      a_i,
  input  logic [htc_pkg::VAL_W-1:0]      b_i,
  output logic [htc_pkg::VAL_W-1:0]      sum_o,
  output logic [htc_pkg::COST_W-1:0]     cost_o
);
  import htc_pkg::*;

  logic [VAL_W-1:0]  sum_q;
  logic [COST_W-1:0] cost_q, cost_d;
  logic [COST_W:0]   cost_ext;

  // Merge sum wraps at the entry width.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sum_q <= a_i + b_i;
    end
  end

  assign cost_ext = {1'b0, cost_q} + {2'b00, sum_q};

  always_comb begin
    cost_d = cost_q;
    if (ctl_i.clear) begin
      cost_d = '0;
    end else if (ctl_i.add) begin
      // Stick at all ones on carry out.
      cost_d = cost_ext[COST_W] ? {COST_W{1'b1}} : cost_ext[COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= '0;
    end else begin
      cost_q <= cost_d;
    end
  end

  assign sum_o  = sum_q;
  assign cost_o = cost_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Huffman total cost testbench
// Streams sets of symbol weights in and checks every cost result against a
// merge-based predictor or a known cost. A short table of directed sets
// comes first; random sets with random idling on both streams follow.
// ---------------------------------------------------------------------------
module tb;
  import htc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned SYMBOL_CAP   = 1024;
  // The directed table already sends about 1045 weights; top up to ~1600.
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 4 * SYMBOL_CAP + 64;

  localparam logic [VAL_W-1:0]    COST_MAX   = {VAL_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  typedef struct packed {
    logic [VAL_W-1:0] cost;
    logic             ovf;
  } cost_result_t;

  // One row of the directed table: a weight sent count times in a row.
  // Where typed is set, the row closes a set and carries its known cost.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                last;
    logic [15:0]         count;
    logic                typed;
    logic [VAL_W-1:0]    cost;
  } stim_row_t;

  localparam int unsigned PLAN_ROWS = 14;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic [31:0]      s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;

  // Weights of the set being collected, kept in ascending order.
  logic [VAL_W-1:0] held_weights [$];
  // Costs still owed by the block, oldest first.
  cost_result_t     pending_costs [$];

  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  int unsigned weights_sent    = 0;
  int unsigned weights_dropped = 0;
  int unsigned sets_closed     = 0;
  int unsigned costs_checked   = 0;
  bit          quiet_tx        = 1'b0;
  bit          quiet_rx        = 1'b0;
  int unsigned rx_hold         = 0;
  cost_result_t seen_cost;

  huffman_total_cost #(
    .MAX_SYMBOLS (SYMBOL_CAP)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Count cycles; abandon the run if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d costs outstanding",
               cycle_count, pending_costs.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Idle length for either stream: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Put a weight into the ascending list of the open set.
  function automatic void hold_weight(input logic [WEIGHT_W-1:0] w);
    int unsigned pos;
    pos = 0;
    while (pos < held_weights.size() && held_weights[pos] <= VAL_W'(w))
      pos++;
    held_weights.insert(pos, VAL_W'(w));
  endfunction

  // Merge the open set down to one value. Merged sums never decrease, so the
  // heads of the sorted leaves and of a second FIFO of sums always hold the
  // two smallest values. The cost is the sum of all merged values, saturating
  // at the top of 64 bits and reported clipped to 63 bits.
  function automatic cost_result_t merge_held_weights();
    logic [VAL_W-1:0]  sums [$];
    logic [VAL_W-1:0]  pick [2];
    logic [VAL_W-1:0]  merged;
    logic [COST_W-1:0] acc;
    cost_result_t      res;
    acc = '0;
    while (held_weights.size() + sums.size() > 1) begin
      for (int k = 0; k < 2; k++) begin
        if (sums.size() == 0 ||
            (held_weights.size() != 0 && held_weights[0] <= sums[0]))
          pick[k] = held_weights.pop_front();
        else
          pick[k] = sums.pop_front();
      end
      merged = pick[0] + pick[1];
      if (COST_W'(merged) > ~acc)
        acc = '1;
      else
        acc = acc + COST_W'(merged);
      sums.insert(sums.size(), merged);
    end
    held_weights.delete();
    res.ovf  = (acc > COST_W'(COST_MAX));
    res.cost = res.ovf ? COST_MAX : acc[VAL_W-1:0];
    return res;
  endfunction

  // Account for one accepted weight request; returns 0 if the row was full.
  function automatic bit note_weight(input logic [WEIGHT_W-1:0] w, input logic lst,
                                     input logic typed, input logic [VAL_W-1:0] cost);
    bit           kept;
    cost_result_t res;
    kept = (held_weights.size() < SYMBOL_CAP);
    weights_sent++;
    if (kept)
      hold_weight(w);
    else
      weights_dropped++;
    if (lst) begin
      res = merge_held_weights();
      if (typed) begin
        res.cost = cost;
        res.ovf  = 1'b0;
      end
      pending_costs.insert(pending_costs.size(), res);
      sets_closed++;
    end
    return kept;
  endfunction

  // Offer one weight after a random gap and hold it until it is taken.
  task automatic send_weight(input logic [WEIGHT_W-1:0] w, input logic lst,
                             input logic typed, input logic [VAL_W-1:0] cost,
                             output bit kept);
    int unsigned gap;
    gap = pick_gap(quiet_tx);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {1'b0, w};
    s_axis_tlast  <= lst;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    kept = note_weight(w, lst, typed, cost);
    if (weights_sent % 40 == 0)
      quiet_tx = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight(input logic [WEIGHT_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WEIGHT_MAX;
      2, 3:    return WEIGHT_W'($urandom_range(0, 15));
      4:       return prev;
      5, 6:    return WEIGHT_W'($urandom >> $urandom_range(1, 30));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Result side: check each accepted result, then stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      costs_checked++;
      if (pending_costs.size() == 0) begin
        flag_mismatch($sformatf("cost %0d arrived with no set closed",
                                m_axis_tdata[VAL_W-1:0]));
      end else begin
        seen_cost = pending_costs.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== seen_cost.cost)
          flag_mismatch($sformatf("total_cost %0d, predicted %0d",
                                  m_axis_tdata[VAL_W-1:0], seen_cost.cost));
        if (m_axis_tuser !== seen_cost.ovf)
          flag_mismatch($sformatf("overflowed %b, predicted %b",
                                  m_axis_tuser, seen_cost.ovf));
      end
    end
    if (cycle_count % 150 == 0)
      quiet_rx <= ($urandom_range(0, 3) == 0);
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        rx_hold <= pick_gap(quiet_rx);
    end
  end

  // Stimulus: directed table, then random sets.
  initial begin
    stim_row_t           plan [PLAN_ROWS];
    logic [WEIGHT_W-1:0] w;
    int unsigned         set_len;
    int unsigned         kept_random;
    bit                  kept;

    // Known costs: a lone weight costs nothing; two equal weights cost
    // their sum; four ones cost 8; a full row of ones is a perfect tree
    // of depth 10, so 10240, with the surplus weights dropped.
    plan = '{
      '{weight: '0,          last: 1'b1, count: 16'd1,    typed: 1'b1, cost: '0},
      '{weight: WEIGHT_MAX,  last: 1'b1, count: 16'd1,    typed: 1'b1, cost: '0},
      '{weight: WEIGHT_MAX,  last: 1'b0, count: 16'd1,    typed: 1'b0, cost: '0},
      '{weight: WEIGHT_MAX,  last: 1'b1, count: 16'd1,    typed: 1'b1,
        cost: 63'hFFFF_FFFE},
      '{weight: '0,          last: 1'b0, count: 16'd1,    typed: 1'b0, cost: '0},
      '{weight: '0,          last: 1'b1, count: 16'd1,    typed: 1'b1, cost: '0},
      '{weight: 31'd1,       last: 1'b0, count: 16'd3,    typed: 1'b0, cost: '0},
      '{weight: 31'd1,       last: 1'b1, count: 16'd1,    typed: 1'b1, cost: 63'd8},
      '{weight: 31'd5,       last: 1'b0, count: 16'd1,    typed: 1'b0, cost: '0},
      '{weight: 31'd2,       last: 1'b0, count: 16'd2,    typed: 1'b0, cost: '0},
      '{weight: 31'h5555_5555, last: 1'b0, count: 16'd1,  typed: 1'b0, cost: '0},
      '{weight: 31'h2AAA_AAAA, last: 1'b1, count: 16'd1,  typed: 1'b0, cost: '0},
      '{weight: 31'd1,       last: 1'b0, count: 16'd1029, typed: 1'b0, cost: '0},
      '{weight: 31'd1,       last: 1'b1, count: 16'd1,    typed: 1'b1, cost: 63'd10240}
    };

    // Hold reset, then release it once.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      for (int n = 0; n < plan[r].count; n++)
        send_weight(plan[r].weight, plan[r].last, plan[r].typed, plan[r].cost, kept);
    end

    // Random sets: mostly short, some middling.
    kept_random = 0;
    w           = '0;
    while (kept_random < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        set_len = $urandom_range(1, 8);
      end else begin
        set_len = $urandom_range(9, 64);
      end
      for (int n = 0; n < set_len; n++) begin
        w = pick_weight(w);
        send_weight(w, (n == set_len - 1), 1'b0, '0, kept);
        if (kept)
          kept_random++;
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    // Drain: wait for every owed cost, then watch for stray results.
    while (pending_costs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d weight requests in %0d sets, %0d of them beyond the row.",
             weights_sent, sets_closed, weights_dropped);
    $display("Checked %0d cost results, %0d mismatches.", costs_checked, mismatches);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
